@@ hw/rtl/snf_pkg.sv @@
// shared types, constants and helpers of the source nat flow table
package snf_pkg;

  localparam int TABLE_ENTRIES   = 1024;
  localparam int BUCKET_WAYS     = 8;
  localparam int PORT_POOL_DEPTH = 1024;

  localparam int NUM_BUCKETS = TABLE_ENTRIES / BUCKET_WAYS;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int WAY_W       = $clog2(BUCKET_WAYS);
  localparam int SLOT_W      = BKT_W + WAY_W;
  localparam int POOL_AW     = $clog2(PORT_POOL_DEPTH);
  localparam int POOL_CNT_W  = $clog2(PORT_POOL_DEPTH + 1);
  localparam int FLOW_SLOT_W = 10;
  localparam int CFG_IDX_W   = 2;

  // hash mixing constants
  localparam logic [31:0] HASH_C1 = 32'h9E3779B1;
  localparam logic [31:0] HASH_C2 = 32'h85EBCA6B;
  localparam logic [31:0] HASH_C3 = 32'h7FEB352D;

  localparam logic [31:0] OFFLOAD_THR_RESET = 32'd100;

  // one flow table entry
  typedef struct packed {
    logic        valid;
    logic [63:0] key_addrs;
    logic [39:0] key_ppp;
    logic [63:0] new_addrs;
    logic [31:0] new_ports;
    logic [31:0] packets;
    logic [31:0] bytes;
    logic        offloading;
    logic [SLOT_W-1:0] partner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int ROW_W   = BUCKET_WAYS * ENTRY_W;

  // one bucket: all ways side by side in one memory word
  typedef entry_t [BUCKET_WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_TABLE_FULL  = 3'd2,
    ST_POOL_EMPTY  = 3'd3,
    ST_POOL_FULL   = 3'd4
  } status_t;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_RETURN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAT_IP      = 2'd0,
    CFG_OFFLOAD_EN  = 2'd1,
    CFG_OFFLOAD_THR = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_READ,
    S_MATCH,
    S_WRFWD,
    S_DONE
  } state_t;

  // saturating 32-bit add
  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

@@ hw/rtl/snf_ram.sv @@
// generic single-port-write ram with registered read
module snf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/snf_hash.sv @@
// two-stage pipelined bucket hash of a five-tuple key
module snf_hash (
  input  logic                    clk,
  input  logic [63:0]             key_addrs,
  input  logic [39:0]             key_ppp,
  output logic [snf_pkg::BKT_W-1:0] bucket
);
  import snf_pkg::*;

  logic [31:0] prod_a;
  logic [31:0] prod_b;
  logic [31:0] lo;
  logic [7:0]  pr;
  logic [31:0] prod_c;
  logic [31:0] folded;
  logic [31:0] mixed;
  logic [31:0] fin;

  // stage one: the two independent products
  always_ff @(posedge clk) begin
    prod_a <= key_addrs[63:32] * HASH_C1;
    prod_b <= key_ppp[39:8] * HASH_C2;
    lo     <= key_addrs[31:0];
    pr     <= key_ppp[7:0];
  end

  // combine and fold before the final product
  always_comb begin
    folded = prod_a ^ lo ^ prod_b ^ {24'b0, pr};
    mixed  = folded ^ (folded >> 16);
  end

  // stage two: final product
  always_ff @(posedge clk) begin
    prod_c <= mixed * HASH_C3;
  end

  // last fold, bucket count is a power of two
  always_comb begin
    fin    = prod_c ^ (prod_c >> 15);
    bucket = fin[BKT_W-1:0];
  end

endmodule

@@ hw/rtl/source_nat_flow_table.sv @@
// top level: source nat flow table with bucketed exact match and free-port pool
// The flow table lives in one memory of NUM_BUCKETS words, each word one
// bucket of all ways, and the free ports in a second memory used as a fifo.
// After reset the block sweeps the table clear, one bucket a cycle, with
// in_ready low; configuration writes are taken throughout. A port return or
// an unsupported packet goes straight from idle to the done state. A lookup
// probes the forward bucket; on a miss with a free way and a free port it
// probes the reverse bucket, and if that probe succeeds it installs the flow
// pair, with a separate write of the forward entry when the reverse entry
// lands in another bucket. Each bucket probe goes through the two-stage hash
// and one registered table read; items are handled one at a time and a
// finished result waits in the output register while the next word is taken.
module source_nat_flow_table (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [snf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic        is_ipv4_l4,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] sport,
  input  logic [15:0] dport,
  input  logic [7:0]  proto,
  input  logic [15:0] pkt_len,
  input  logic [15:0] free_port,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] new_src_ip,
  output logic [31:0] new_dst_ip,
  output logic [15:0] new_src_port,
  output logic [15:0] new_dst_port,
  output logic        flow_created,
  output logic        offload_request,
  output logic [snf_pkg::FLOW_SLOT_W-1:0] flow_slot,
  output logic [31:0] flow_packets
);
  import snf_pkg::*;

  state_t state, state_next;

  // configuration registers
  logic [31:0] nat_ip;
  logic        offload_en;
  logic [31:0] offload_thr;

  // latched input word
  logic [31:0] in_sip, in_dip;
  logic [15:0] in_sp, in_dp, in_len;
  logic [7:0]  in_pr;

  // pool state
  logic [POOL_AW-1:0]    pool_head, pool_tail;
  logic [POOL_CNT_W-1:0] pool_count;
  logic                  pool_we, pool_re;
  logic [15:0]           pool_rdata;

  // table access
  logic             tbl_we, tbl_re;
  logic [BKT_W-1:0] tbl_waddr;
  row_t             tbl_wdata;
  row_t             tbl_rdata;
  logic [BKT_W-1:0] clr_idx;

  // probe state
  logic             phase_rev;
  logic [BKT_W-1:0] hash_bucket, cur_bucket, fwd_bucket;
  logic [WAY_W-1:0] fwd_way;
  logic [SLOT_W-1:0] rev_slot;
  row_t             fwd_row;
  logic [63:0]      fwd_addrs, rev_addrs, key_addrs;
  logic [39:0]      fwd_ppp, rev_ppp, key_ppp;

  // pending result
  status_t          res_status;
  logic [31:0]      res_src_ip, res_dst_ip, res_pkts;
  logic [15:0]      res_sp, res_dp;
  logic             res_created, res_offload;
  logic [SLOT_W-1:0] res_slot;

  // match decisions
  logic             hit_any, free_any, same_bucket, rev_conflict;
  logic [WAY_W-1:0] hit_way, free_way;
  entry_t           hit_entry, upd_entry, fwd_entry, rev_entry;
  logic [31:0]      upd_pkts;
  logic             upd_offload;
  logic             in_take, out_load;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // keys of the current packet
  assign fwd_addrs = {in_sip, in_dip};
  assign fwd_ppp   = {in_sp, in_dp, in_pr};
  assign rev_addrs = {in_dip, nat_ip};
  assign rev_ppp   = {in_dp, pool_rdata, in_pr};
  assign key_addrs = phase_rev ? rev_addrs : fwd_addrs;
  assign key_ppp   = phase_rev ? rev_ppp : fwd_ppp;

  snf_hash u_hash (
    .clk       (clk),
    .key_addrs (key_addrs),
    .key_ppp   (key_ppp),
    .bucket    (hash_bucket)
  );

  snf_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (hash_bucket),
    .rdata (tbl_rdata)
  );

  snf_ram #(.WIDTH(16), .DEPTH(PORT_POOL_DEPTH)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_tail),
    .wdata (free_port),
    .re    (pool_re),
    .raddr (pool_head),
    .rdata (pool_rdata)
  );

  // way search over the bucket just read
  always_comb begin
    hit_any     = 1'b0;
    free_any    = 1'b0;
    hit_way     = '0;
    free_way    = '0;
    same_bucket = phase_rev && (cur_bucket == fwd_bucket);
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (tbl_rdata[w].valid && tbl_rdata[w].key_addrs == key_addrs &&
          tbl_rdata[w].key_ppp == key_ppp) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!tbl_rdata[w].valid && !(same_bucket && fwd_way == WAY_W'(w))) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    rev_conflict = hit_any || !free_any ||
                   (rev_addrs == fwd_addrs && rev_ppp == fwd_ppp);
  end

  // hit update and the two new entries
  always_comb begin
    hit_entry   = tbl_rdata[hit_way];
    upd_pkts    = sat_add32(hit_entry.packets, 32'd1);
    upd_offload = offload_en && (upd_pkts >= offload_thr) && !hit_entry.offloading;
    upd_entry   = hit_entry;
    upd_entry.packets    = upd_pkts;
    upd_entry.bytes      = sat_add32(hit_entry.bytes, {16'b0, in_len});
    upd_entry.offloading = hit_entry.offloading || upd_offload;

    fwd_entry.valid      = 1'b1;
    fwd_entry.key_addrs  = fwd_addrs;
    fwd_entry.key_ppp    = fwd_ppp;
    fwd_entry.new_addrs  = {nat_ip, in_dip};
    fwd_entry.new_ports  = {pool_rdata, in_dp};
    fwd_entry.packets    = 32'd1;
    fwd_entry.bytes      = {16'b0, in_len};
    fwd_entry.offloading = 1'b0;
    fwd_entry.partner    = (state == S_WRFWD) ? rev_slot : {cur_bucket, free_way};

    rev_entry.valid      = 1'b1;
    rev_entry.key_addrs  = rev_addrs;
    rev_entry.key_ppp    = rev_ppp;
    rev_entry.new_addrs  = {in_dip, in_sip};
    rev_entry.new_ports  = {in_dp, in_sp};
    rev_entry.packets    = 32'd0;
    rev_entry.bytes      = 32'd0;
    rev_entry.offloading = 1'b0;
    rev_entry.partner    = {fwd_bucket, fwd_way};
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == BKT_W'(NUM_BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_take) begin
          if (action == ACT_LOOKUP && is_ipv4_l4) state_next = S_HASH1;
          else                                    state_next = S_DONE;
        end
      end
      S_HASH1: state_next = S_HASH2;
      S_HASH2: state_next = S_READ;
      S_READ:  state_next = S_MATCH;
      S_MATCH: begin
        if (!phase_rev) begin
          if (!hit_any && pool_count != '0 && free_any) state_next = S_HASH1;
          else                                          state_next = S_DONE;
        end else if (rev_conflict || same_bucket) begin
          state_next = S_DONE;
        end else begin
          state_next = S_WRFWD;
        end
      end
      S_WRFWD: state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    in_ready  = (state == S_IDLE);
    tbl_re    = (state == S_READ);
    tbl_we    = 1'b0;
    tbl_waddr = cur_bucket;
    tbl_wdata = tbl_rdata;
    pool_re   = in_take && action == ACT_LOOKUP;
    pool_we   = in_take && action == ACT_RETURN &&
                pool_count < POOL_CNT_W'(PORT_POOL_DEPTH);
    unique case (state)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_idx;
        tbl_wdata = '0;
      end
      S_MATCH: begin
        if (!phase_rev) begin
          tbl_we = hit_any;
          tbl_wdata[hit_way] = upd_entry;
        end else if (!rev_conflict) begin
          tbl_we = 1'b1;
          tbl_wdata[free_way] = rev_entry;
          if (same_bucket) tbl_wdata[fwd_way] = fwd_entry;
        end
      end
      S_WRFWD: begin
        tbl_we    = 1'b1;
        tbl_waddr = fwd_bucket;
        tbl_wdata = fwd_row;
        tbl_wdata[fwd_way] = fwd_entry;
      end
      S_IDLE, S_HASH1, S_HASH2, S_READ, S_DONE: begin
        tbl_we = 1'b0;
      end
      default: tbl_we = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nat_ip      <= '0;
      offload_en  <= 1'b1;
      offload_thr <= OFFLOAD_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NAT_IP:      nat_ip      <= cfg_data;
        CFG_OFFLOAD_EN:  offload_en  <= cfg_data[0];
        CFG_OFFLOAD_THR: offload_thr <= cfg_data;
        CFG_UNUSED:      nat_ip      <= nat_ip;
        default:         nat_ip      <= nat_ip;
      endcase
    end
  end

  // control registers: sweep, probe phase, pool pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      phase_rev  <= 1'b0;
      pool_head  <= '0;
      pool_tail  <= '0;
      pool_count <= '0;
    end else begin
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (in_take) phase_rev <= 1'b0;
      if (state == S_MATCH && state_next == S_HASH1) phase_rev <= 1'b1;
      if (pool_we) begin
        pool_tail  <= (pool_tail == POOL_AW'(PORT_POOL_DEPTH - 1)) ? '0 : pool_tail + 1'b1;
        pool_count <= pool_count + 1'b1;
      end
      if (state == S_MATCH && phase_rev && !rev_conflict) begin
        pool_head  <= (pool_head == POOL_AW'(PORT_POOL_DEPTH - 1)) ? '0 : pool_head + 1'b1;
        pool_count <= pool_count - 1'b1;
      end
    end
  end

  // payload registers: input latch, probe context, pending result
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sip <= src_ip;
      in_dip <= dst_ip;
      in_sp  <= sport;
      in_dp  <= dport;
      in_pr  <= proto;
      in_len <= pkt_len;
      res_created <= 1'b0;
      res_offload <= 1'b0;
      res_slot    <= '0;
      res_pkts    <= '0;
      if (action == ACT_RETURN) begin
        res_status <= pool_we ? ST_OK : ST_POOL_FULL;
        res_src_ip <= '0;
        res_dst_ip <= '0;
        res_sp     <= '0;
        res_dp     <= '0;
      end else begin
        res_status <= is_ipv4_l4 ? ST_OK : ST_UNSUPPORTED;
        res_src_ip <= src_ip;
        res_dst_ip <= dst_ip;
        res_sp     <= sport;
        res_dp     <= dport;
      end
    end
    if (state == S_READ) cur_bucket <= hash_bucket;
    if (state == S_MATCH) begin
      if (!phase_rev) begin
        fwd_bucket <= cur_bucket;
        fwd_way    <= free_way;
        fwd_row    <= tbl_rdata;
        if (hit_any) begin
          res_src_ip  <= hit_entry.new_addrs[63:32];
          res_dst_ip  <= hit_entry.new_addrs[31:0];
          res_sp      <= hit_entry.new_ports[31:16];
          res_dp      <= hit_entry.new_ports[15:0];
          res_slot    <= {cur_bucket, hit_way};
          res_pkts    <= upd_pkts;
          res_offload <= upd_offload;
        end else if (pool_count == '0) begin
          res_status <= ST_POOL_EMPTY;
        end else if (!free_any) begin
          res_status <= ST_TABLE_FULL;
        end
      end else if (rev_conflict) begin
        res_status <= ST_TABLE_FULL;
      end else begin
        rev_slot    <= {cur_bucket, free_way};
        res_src_ip  <= nat_ip;
        res_dst_ip  <= in_dip;
        res_sp      <= pool_rdata;
        res_dp      <= in_dp;
        res_slot    <= {fwd_bucket, fwd_way};
        res_pkts    <= 32'd1;
        res_created <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= res_status;
      new_src_ip      <= res_src_ip;
      new_dst_ip      <= res_dst_ip;
      new_src_port    <= res_sp;
      new_dst_port    <= res_dp;
      flow_created    <= res_created;
      offload_request <= res_offload;
      flow_slot       <= FLOW_SLOT_W'(res_slot);
      flow_packets    <= res_pkts;
    end
  end

  // pool never holds more ports than its depth
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    pool_count <= POOL_CNT_W'(PORT_POOL_DEPTH))
    else $error("pool count above depth");

  // a created flow is always an ok result without offload
  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && flow_created |-> status == ST_OK && !offload_request)
    else $error("created flow with bad status");

  // no table write while waiting for a word
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !tbl_we)
    else $error("table write while idle");

  // a new result only follows the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result without done state");

endmodule

@@ bench/tb_top.sv @@
// testbench for the source nat flow table: random and directed words checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import snf_pkg::*;

  // one packet or port-return word
  typedef struct {
    logic        act;
    logic        l4;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  pr;
    logic [15:0] len;
    logic [15:0] fport;
  } pkt_word_t;

  // one result word
  typedef struct {
    status_t     st;
    logic [31:0] nsip;
    logic [31:0] ndip;
    logic [15:0] nsp;
    logic [15:0] ndp;
    logic        created;
    logic        offl;
    logic [9:0]  slot;
    logic [31:0] pkts;
  } nat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0, is_ipv4_l4 = 1'b0;
  logic [31:0] src_ip = '0, dst_ip = '0;
  logic [15:0] sport = '0, dport = '0, pkt_len = '0, free_port = '0;
  logic [7:0] proto = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [31:0] new_src_ip, new_dst_ip, flow_packets;
  logic [15:0] new_src_port, new_dst_port;
  logic flow_created, offload_request;
  logic [FLOW_SLOT_W-1:0] flow_slot;

  source_nat_flow_table dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [31:0] nat_ip;
  logic        offl_en;
  logic [31:0] offl_thr;
  logic        t_valid [TABLE_ENTRIES];
  logic [63:0] t_addrs [TABLE_ENTRIES];
  logic [39:0] t_ppp [TABLE_ENTRIES];
  logic [63:0] t_naddrs [TABLE_ENTRIES];
  logic [31:0] t_nports [TABLE_ENTRIES];
  logic [31:0] t_pkts [TABLE_ENTRIES];
  logic [31:0] t_bytes [TABLE_ENTRIES];
  logic        t_offl [TABLE_ENTRIES];
  logic [15:0] port_fifo [$];

  pkt_word_t   pending_words [$];
  nat_result_t expected_results [$];
  int fail_count = 0;
  bit quiet = 0;       // no idling in the last part
  bit hold_send = 0;   // sender hold-off
  int in_gap = 0, out_gap = 0;

  // captured flows, reused to drive hits
  pkt_word_t known_flows [$];

  function automatic int bucket_of(logic [63:0] a, logic [39:0] p);
    logic [31:0] x;
    x = a[63:32] * HASH_C1;
    x ^= a[31:0];
    x ^= p[39:8] * HASH_C2;
    x ^= {24'd0, p[7:0]};
    x ^= x >> 16;
    x = x * HASH_C3;
    x ^= x >> 15;
    return int'(x % NUM_BUCKETS);
  endfunction

  function automatic int lookup_slot(logic [63:0] a, logic [39:0] p);
    int b;
    b = bucket_of(a, p) * BUCKET_WAYS;
    for (int w = 0; w < BUCKET_WAYS; w++)
      if (t_valid[b+w] && t_addrs[b+w] == a && t_ppp[b+w] == p) return b + w;
    return -1;
  endfunction

  function automatic int free_slot(logic [63:0] a, logic [39:0] p, int skip);
    int b;
    b = bucket_of(a, p) * BUCKET_WAYS;
    for (int w = 0; w < BUCKET_WAYS; w++)
      if (!t_valid[b+w] && (b + w) != skip) return b + w;
    return -1;
  endfunction

  function automatic void put_entry(int s, logic [63:0] a, logic [39:0] p, logic [63:0] na,
                                    logic [31:0] np, logic [31:0] pk, logic [31:0] by);
    t_valid[s] = 1'b1; t_addrs[s] = a; t_ppp[s] = p; t_naddrs[s] = na;
    t_nports[s] = np; t_pkts[s] = pk; t_bytes[s] = by; t_offl[s] = 1'b0;
  endfunction

  function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[32] ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  // computes the translation result of one word and advances the table
  function automatic nat_result_t translate(pkt_word_t w);
    nat_result_t r;
    logic [63:0] a, ra;
    logic [39:0] p, rp;
    logic [15:0] port;
    int s, q;
    r = '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0};
    if (w.act == ACT_RETURN) begin
      if (port_fifo.size() >= PORT_POOL_DEPTH) r.st = ST_POOL_FULL;
      else port_fifo.push_back(w.fport);
      return r;
    end
    r.nsip = w.sip; r.ndip = w.dip; r.nsp = w.sp; r.ndp = w.dp;
    if (!w.l4) begin
      r.st = ST_UNSUPPORTED;
      return r;
    end
    a = {w.sip, w.dip};
    p = {w.sp, w.dp, w.pr};
    s = lookup_slot(a, p);
    if (s < 0) begin
      if (port_fifo.size() == 0) begin
        r.st = ST_POOL_EMPTY;
        return r;
      end
      port = port_fifo[0];
      ra = {w.dip, nat_ip};
      rp = {w.dp, port, w.pr};
      s = free_slot(a, p, -1);
      q = (s < 0) ? -1 : free_slot(ra, rp, s);
      if (q < 0 || (ra == a && rp == p) || lookup_slot(ra, rp) >= 0) begin
        r.st = ST_TABLE_FULL;
        return r;
      end
      void'(port_fifo.pop_front());
      put_entry(s, a, p, {nat_ip, w.dip}, {port, w.dp}, 1, {16'd0, w.len});
      put_entry(q, ra, rp, {w.dip, w.sip}, {w.dp, w.sp}, 0, 0);
      r.created = 1'b1;
    end else begin
      t_pkts[s] = sat32(t_pkts[s], 1);
      t_bytes[s] = sat32(t_bytes[s], {16'd0, w.len});
      if (offl_en && t_pkts[s] >= offl_thr && !t_offl[s]) begin
        t_offl[s] = 1'b1;
        r.offl = 1'b1;
      end
    end
    r.nsip = t_naddrs[s][63:32]; r.ndip = t_naddrs[s][31:0];
    r.nsp = t_nports[s][31:16]; r.ndp = t_nports[s][15:0];
    r.slot = s[9:0];
    r.pkts = t_pkts[s];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  // driver: moves pending words to the block
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) expected_results.push_back(translate(pending_words.pop_front()));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !hold_send
                     && !(quiet == 0 && $urandom_range(0, 9) == 0)) begin
          action <= pending_words[0].act; is_ipv4_l4 <= pending_words[0].l4;
          src_ip <= pending_words[0].sip; dst_ip <= pending_words[0].dip;
          sport <= pending_words[0].sp; dport <= pending_words[0].dp;
          proto <= pending_words[0].pr; pkt_len <= pending_words[0].len;
          free_port <= pending_words[0].fport;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (!quiet && pending_words.size() > 0 && !hold_send) in_gap <= $urandom_range(0, 3);
        end
      end
    end
  end

  // monitor: checks each result word and drives out_ready
  always @(posedge clk) begin
    nat_result_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", status, 0);
        end else begin
          e = expected_results.pop_front();
          if (status !== e.st) report_mismatch("status", status, e.st);
          if (new_src_ip !== e.nsip) report_mismatch("new_src_ip", new_src_ip, e.nsip);
          if (new_dst_ip !== e.ndip) report_mismatch("new_dst_ip", new_dst_ip, e.ndip);
          if (new_src_port !== e.nsp) report_mismatch("new_src_port", new_src_port, e.nsp);
          if (new_dst_port !== e.ndp) report_mismatch("new_dst_port", new_dst_port, e.ndp);
          if (flow_created !== e.created)
            report_mismatch("flow_created", flow_created, e.created);
          if (offload_request !== e.offl)
            report_mismatch("offload_request", offload_request, e.offl);
          if (flow_slot !== e.slot) report_mismatch("flow_slot", flow_slot, e.slot);
          if (flow_packets !== e.pkts) report_mismatch("flow_packets", flow_packets, e.pkts);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // queues one word
  task automatic add_word(logic act, logic l4, logic [31:0] sip, logic [31:0] dip,
                          logic [15:0] sp, logic [15:0] dp, logic [7:0] pr,
                          logic [15:0] len, logic [15:0] fport);
    pkt_word_t w;
    w = '{act, l4, sip, dip, sp, dp, pr, len, fport};
    pending_words.push_back(w);
    if (act == ACT_LOOKUP && l4) known_flows.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NAT_IP:      nat_ip = val;
      CFG_OFFLOAD_EN:  offl_en = val[0];
      CFG_OFFLOAD_THR: offl_thr = val;
      default: ;
    endcase
  endtask

  // random word: mostly flows and hits of known flows, some returns and noise
  task automatic add_random();
    int k;
    pkt_word_t f;
    k = $urandom_range(0, 99);
    if (k < 12) begin
      add_word(ACT_RETURN, 1'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
               8'($urandom), 16'($urandom), 16'($urandom));
    end else if (k < 17) begin
      add_word(ACT_LOOKUP, 1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom),
               8'($urandom), 16'($urandom), 16'($urandom));
    end else if (k < 60 && known_flows.size() > 0) begin
      f = known_flows[$urandom_range(0, known_flows.size() - 1)];
      add_word(ACT_LOOKUP, 1'b1, f.sip, f.dip, f.sp, f.dp, f.pr, 16'($urandom),
               16'($urandom));
    end else begin
      add_word(ACT_LOOKUP, 1'b1, $urandom, $urandom, 16'($urandom), 16'($urandom),
               8'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int fill_n;
    nat_ip = 0; offl_en = 1; offl_thr = 100;
    for (int i = 0; i < TABLE_ENTRIES; i++) t_valid[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pool, unsupported type, field extremes
    write_reg(CFG_NAT_IP, 32'hC0A8_0101);
    write_reg(CFG_OFFLOAD_THR, 3);
    add_word(ACT_LOOKUP, 1, '1, '1, '1, '1, '1, '1, 0);
    add_word(ACT_LOOKUP, 0, 0, 0, 0, 0, 0, 0, '1);
    add_word(ACT_LOOKUP, 0, '1, '1, '1, '1, '1, '1, '1);
    add_word(ACT_RETURN, 0, 0, 0, 0, 0, 0, 0, 16'd1000);
    add_word(ACT_RETURN, 1, 0, 0, 0, 0, 0, 0, 16'hFFFF);
    add_word(ACT_RETURN, 0, 0, 0, 0, 0, 0, 0, 16'h0000);
    // create, then hit until offload, then beyond
    add_word(ACT_LOOKUP, 1, 32'h0A00_0001, 32'h0808_0808, 1234, 53, 17, 100, 0);
    repeat (4) add_word(ACT_LOOKUP, 1, 32'h0A00_0001, 32'h0808_0808, 1234, 53, 17, '1, 0);
    // reply traffic through the reverse entry
    add_word(ACT_LOOKUP, 1, 32'h0808_0808, 32'hC0A8_0101, 53, 1000, 17, 60, 0);
    add_word(ACT_LOOKUP, 1, 0, 0, 0, 0, 0, 0, 0);
    add_word(ACT_LOOKUP, 1, 0, 0, 0, 0, 0, 0, 0);
    // source, destination and nat address all equal
    add_word(ACT_LOOKUP, 1, 32'hC0A8_0101, 32'hC0A8_0101, 16'd7, 16'd7, 6, 1, 0);
    wait_drained();

    // threshold zero, offload disabled, extreme address
    write_reg(CFG_OFFLOAD_THR, 0);
    for (int i = 0; i < 3; i++) add_word(ACT_RETURN, 0, 0, 0, 0, 0, 0, 0, 16'(2000 + i));
    add_word(ACT_LOOKUP, 1, 32'h0A00_0001, 32'h0808_0808, 1234, 53, 17, 1, 0);
    add_word(ACT_LOOKUP, 1, 32'h1, 32'h2, 3, 4, 6, 5, 0);
    add_word(ACT_LOOKUP, 1, 32'h1, 32'h2, 3, 4, 6, 5, 0);
    wait_drained();
    write_reg(CFG_OFFLOAD_EN, 0);
    write_reg(CFG_NAT_IP, 32'hFFFF_FFFF);
    write_reg(CFG_OFFLOAD_THR, 32'hFFFF_FFFF);
    for (int i = 0; i < 25; i++) add_random();
    // pressure: wait for all results before more words
    hold_send = 1;
    while (expected_results.size() > 0 || in_valid) @(posedge clk);
    hold_send = 0;
    wait_drained();

    write_reg(CFG_OFFLOAD_EN, 1);
    write_reg(CFG_NAT_IP, 32'h0);
    write_reg(CFG_OFFLOAD_THR, 2);
    for (int i = 0; i < 25; i++) add_random();
    wait_drained();

    // fill the pool to overflow
    fill_n = PORT_POOL_DEPTH - port_fifo.size() + 4;
    for (int i = 0; i < fill_n; i++) begin
      add_word(ACT_RETURN, 0, 0, 0, 0, 0, 0, 0, 16'($urandom));
      while (pending_words.size() > 8) @(posedge clk);
    end
    wait_drained();
    write_reg(CFG_OFFLOAD_THR, 1);
    write_reg(CFG_NAT_IP, 32'h5A5A_A5A5);
    for (int i = 0; i < 30; i++) add_random();
    while (pending_words.size() > 10) @(posedge clk);
    quiet = 1;
    wait_drained();
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("** source_nat_flow_table: PASSED **");
    else $display("** source_nat_flow_table: FAILED **");
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("** source_nat_flow_table: FAILED **");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/snf_pkg.sv
hw/rtl/snf_ram.sv
hw/rtl/snf_hash.sv
hw/rtl/source_nat_flow_table.sv
bench/tb_top.sv
